// ----- rtl/pcrs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrs_pkg
// Shared types and constants of the per-channel requantization core.
// ----------------------------------------------------------------------------
package pcrs_pkg;

   // Item kinds carried on the request tuser bit.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Layout modes.
   localparam logic MODE_CHANNEL_LAST  = 1'b0;
   localparam logic MODE_CHANNEL_FIRST = 1'b1;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAYOUT_MODE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAYOUT_SPAN   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_AMOUNT  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROUND_ENABLE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_OFFSET  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_OFFSET = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_MIN    = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_MAX    = 3'd7;

   // Field widths.
   localparam int DATA_W  = 32;
   localparam int SPAN_W  = 24;
   localparam int SHIFT_W = 5;
   localparam int RES_W   = 8;
   localparam int CIDX_W  = 8;

   // Reset values of the configuration registers.
   localparam logic [SPAN_W-1:0]       SPAN_RESET    = 24'd1;
   localparam logic signed [RES_W-1:0] OUT_MIN_RESET = -8'sd128;
   localparam logic signed [RES_W-1:0] OUT_MAX_RESET = 8'sd127;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic                      layout_mode;
      logic [SPAN_W-1:0]         layout_span;
      logic [SHIFT_W-1:0]        shift_amount;
      logic                      round_enable;
      logic [DATA_W-1:0]         in_offset;
      logic [DATA_W-1:0]         out_offset;
      logic signed [RES_W-1:0]   clamp_lo;
      logic signed [RES_W-1:0]   clamp_hi;
   } cfg_type;

   // One sample on its way from the front to the back.
   typedef struct packed {
      logic [DATA_W-1:0] offset_sample;
      logic [DATA_W-1:0] multiplier;
      logic [DATA_W-1:0] addend;
   } work_type;

endpackage

// ----- rtl/pcrs_ram.sv -----
// ----------------------------------------------------------------------------
// pcrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pcrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pcrs_front.sv -----
// ----------------------------------------------------------------------------
// pcrs_front
// Accepts request items, writes coefficient loads into the channel tables,
// tracks the channel of each sample and fetches its coefficients.
// ----------------------------------------------------------------------------
module pcrs_front import pcrs_pkg::*; #(
   parameter int MAX_CHANNELS = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_opcode,
   input  logic                req_last,
   input  logic [DATA_W-1:0]   req_sample,
   input  logic [CIDX_W-1:0]   req_coeff_channel,
   input  logic [DATA_W-1:0]   req_coeff_multiplier,
   input  logic [DATA_W-1:0]   req_coeff_addend,
   output logic                work_valid,
   input  logic                work_ready,
   output work_type            work_data
);

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int IDX_W = CH_W + CIDX_W;
   localparam int CMP_W = SPAN_W + 1;

   logic [CH_W-1:0]         chan_ff, chan_in;
   logic [SPAN_W-1:0]       pos_ff, pos_in;
   logic                    stage_valid_ff, stage_valid_in;
   logic [DATA_W-1:0]       stage_x_ff, stage_x_in;
   logic                    stage_free, accept, take_sample, take_load;
   logic [SPAN_W-1:0]       span_eff;
   logic [CMP_W-1:0]        next_chan, next_pos;
   logic [IDX_W-1:0]        load_idx;
   logic                    load_hit;
   logic signed [SAMPLE_WIDTH-1:0] narrow_sample;
   logic [DATA_W-1:0]       wide_sample;
   logic [DATA_W-1:0]       mul_rd, add_rd;

   // The fetch stage moves on when it is empty or the queue takes its item.
   assign stage_free  = !stage_valid_ff || work_ready;
   assign req_tready  = stage_free;
   assign accept      = req_tvalid && req_tready;
   assign take_sample = accept && (req_opcode == OP_SAMPLE);
   assign take_load   = accept && (req_opcode == OP_LOAD);

   // Coefficient loads beyond the table depth are dropped.
   assign load_idx = IDX_W'(req_coeff_channel);
   assign load_hit = take_load && (load_idx < IDX_W'(MAX_CHANNELS));

   pcrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_mul_ram (
      .clock   (clock),
      .wr_en   (load_hit),
      .wr_addr (load_idx[CH_W-1:0]),
      .wr_data (req_coeff_multiplier),
      .rd_en   (take_sample),
      .rd_addr (chan_ff),
      .rd_data (mul_rd)
   );

   pcrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_add_ram (
      .clock   (clock),
      .wr_en   (load_hit),
      .wr_addr (load_idx[CH_W-1:0]),
      .wr_data (req_coeff_addend),
      .rd_en   (take_sample),
      .rd_addr (chan_ff),
      .rd_data (add_rd)
   );

   // Channel tracking: steps per sample or per plane, cleared at tensor end.
   always_comb begin
      span_eff  = (cfg.layout_span == '0) ? SPAN_W'(1) : cfg.layout_span;
      next_chan = CMP_W'(chan_ff) + CMP_W'(1);
      next_pos  = CMP_W'(pos_ff) + CMP_W'(1);
      chan_in   = chan_ff;
      pos_in    = pos_ff;
      if (take_sample) begin
         if (req_last) begin
            chan_in = '0;
            pos_in  = '0;
         end else if (cfg.layout_mode == MODE_CHANNEL_LAST) begin
            pos_in = '0;
            if (next_chan >= CMP_W'(span_eff) || next_chan >= CMP_W'(MAX_CHANNELS)) begin
               chan_in = '0;
            end else begin
               chan_in = next_chan[CH_W-1:0];
            end
         end else begin
            if (next_pos >= CMP_W'(span_eff)) begin
               pos_in = '0;
               if (next_chan >= CMP_W'(MAX_CHANNELS)) begin
                  chan_in = '0;
               end else begin
                  chan_in = next_chan[CH_W-1:0];
               end
            end else begin
               pos_in = next_pos[SPAN_W-1:0];
            end
         end
      end
   end

   // Sign-extend the sample and add the input offset.
   always_comb begin
      narrow_sample  = req_sample[SAMPLE_WIDTH-1:0];
      wide_sample    = DATA_W'(narrow_sample);
      stage_x_in     = stage_x_ff;
      stage_valid_in = stage_valid_ff;
      if (stage_free) begin
         stage_valid_in = take_sample;
      end
      if (take_sample) begin
         stage_x_in = wide_sample + cfg.in_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff        <= '0;
         pos_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         chan_ff        <= chan_in;
         pos_ff         <= pos_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_x_ff <= stage_x_in;
   end

   assign work_valid              = stage_valid_ff;
   assign work_data.offset_sample = stage_x_ff;
   assign work_data.multiplier    = mul_rd;
   assign work_data.addend        = add_rd;

endmodule

// ----- rtl/pcrs_queue.sv -----
// ----------------------------------------------------------------------------
// pcrs_queue
// Short first-in first-out queue of fetched samples between front and back.
// ----------------------------------------------------------------------------
module pcrs_queue import pcrs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   work_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   // The input side only sees the registered fill level.
   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- rtl/pcrs_back.sv -----
// ----------------------------------------------------------------------------
// pcrs_back
// Arithmetic pipeline: multiply, add addend, round and shift, add output
// offset and clamp to eight bits, with a registered result stage.
// ----------------------------------------------------------------------------
module pcrs_back import pcrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                work_valid,
   output logic                work_ready,
   input  work_type            work_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RES_W-1:0]    rsp_tdata
);

   logic              mul_valid_ff, mul_valid_in;
   logic [DATA_W-1:0] mul_prod_ff, mul_prod_in;
   logic [DATA_W-1:0] mul_add_ff, mul_add_in;
   logic              sum_valid_ff, sum_valid_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic              shf_valid_ff, shf_valid_in;
   logic [DATA_W-1:0] shf_ff, shf_in;
   logic              out_valid_ff, out_valid_in;
   logic [RES_W-1:0]  out_ff, out_in;
   logic              out_free, shf_free, sum_free, mul_free;
   logic [DATA_W-1:0] bias, rounded, offset_val;
   logic signed [DATA_W-1:0] sv, lo, hi;

   // Each stage refills when it is empty or its content moves on.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign shf_free   = !shf_valid_ff || out_free;
   assign sum_free   = !sum_valid_ff || shf_free;
   assign mul_free   = !mul_valid_ff || sum_free;
   assign work_ready = mul_free;

   // Multiply stage: low 32 bits of the product.
   always_comb begin
      mul_valid_in = mul_free ? work_valid : mul_valid_ff;
      mul_prod_in  = mul_prod_ff;
      mul_add_in   = mul_add_ff;
      if (mul_free && work_valid) begin
         mul_prod_in = DATA_W'(work_data.offset_sample * work_data.multiplier);
         mul_add_in  = work_data.addend;
      end
   end

   // Addend stage.
   always_comb begin
      sum_valid_in = sum_free ? mul_valid_ff : sum_valid_ff;
      sum_in       = sum_ff;
      if (sum_free && mul_valid_ff) begin
         sum_in = mul_prod_ff + mul_add_ff;
      end
   end

   // Rounding bias and arithmetic shift; no bias when the shift is zero.
   always_comb begin
      bias = '0;
      if (cfg.round_enable && cfg.shift_amount != '0) begin
         bias = DATA_W'(1) << (cfg.shift_amount - SHIFT_W'(1));
      end
      rounded      = sum_ff + bias;
      shf_valid_in = shf_free ? sum_valid_ff : shf_valid_ff;
      shf_in       = shf_ff;
      if (shf_free && sum_valid_ff) begin
         shf_in = DATA_W'($signed(rounded) >>> cfg.shift_amount);
      end
   end

   // Output offset and clamp; the upper bound is tested first.
   always_comb begin
      offset_val   = shf_ff + cfg.out_offset;
      sv           = $signed(offset_val);
      lo           = DATA_W'(cfg.clamp_lo);
      hi           = DATA_W'(cfg.clamp_hi);
      out_valid_in = out_free ? shf_valid_ff : out_valid_ff;
      out_in       = out_ff;
      if (out_free && shf_valid_ff) begin
         if (sv > hi) begin
            out_in = cfg.clamp_hi;
         end else if (sv < lo) begin
            out_in = cfg.clamp_lo;
         end else begin
            out_in = sv[RES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         shf_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         sum_valid_ff <= sum_valid_in;
         shf_valid_ff <= shf_valid_in;
         out_valid_ff <= out_valid_in;
      end
      mul_prod_ff <= mul_prod_in;
      mul_add_ff  <= mul_add_in;
      sum_ff      <= sum_in;
      shf_ff      <= shf_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ----- rtl/per_channel_requant_shift_core.sv -----
// ----------------------------------------------------------------------------
// per_channel_requant_shift_core
// Per-channel integer requantization of a signed sample stream to 8 bits.
// Result path: fetch stage, queue, then multiply, addend, shift and result
// registers; coefficient loads give no result. Throughput: one item per
// cycle unless the output stalls; every stage, a full queue apart, refills in
// the cycle it drains, and each coefficient table has its own write and read port.
// Reset: clears handshake state, channel counters and configuration to its
// reset values; coefficient tables are undefined until loaded.
// ----------------------------------------------------------------------------
module per_channel_requant_shift_core import pcrs_pkg::*; #(
   parameter int MAX_CHANNELS = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: sample_value[31:0], coeff_channel[39:32],
   //        coeff_multiplier[71:40], coeff_addend[103:72]
   input  logic [103:0]          req_tdata,
   // tuser: opcode (0 coefficient load, 1 sample)
   input  logic                  req_tuser,
   // tlast: last_of_tensor
   input  logic                  req_tlast,
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: result_value[7:0]
   output logic [RES_W-1:0]      rsp_tdata,
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DATA_W-1:0]     csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     work_valid, work_ready, back_valid, back_ready;
   work_type work_data, back_data;

   // Configuration register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LAYOUT_MODE:   cfg_in.layout_mode  = csr_wdata[0];
            CSR_LAYOUT_SPAN:   cfg_in.layout_span  = csr_wdata[SPAN_W-1:0];
            CSR_SHIFT_AMOUNT:  cfg_in.shift_amount = csr_wdata[SHIFT_W-1:0];
            CSR_ROUND_ENABLE:  cfg_in.round_enable = csr_wdata[0];
            CSR_INPUT_OFFSET:  cfg_in.in_offset    = csr_wdata;
            CSR_OUTPUT_OFFSET: cfg_in.out_offset   = csr_wdata;
            CSR_OUTPUT_MIN:    cfg_in.clamp_lo     = csr_wdata[RES_W-1:0];
            CSR_OUTPUT_MAX:    cfg_in.clamp_hi     = csr_wdata[RES_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_mode  <= MODE_CHANNEL_LAST;
         cfg_ff.layout_span  <= SPAN_RESET;
         cfg_ff.shift_amount <= '0;
         cfg_ff.round_enable <= 1'b0;
         cfg_ff.in_offset    <= '0;
         cfg_ff.out_offset   <= '0;
         cfg_ff.clamp_lo     <= OUT_MIN_RESET;
         cfg_ff.clamp_hi     <= OUT_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, load tables, track channels, fetch coefficients.
   pcrs_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_opcode           (req_tuser),
      .req_last             (req_tlast),
      .req_sample           (req_tdata[31:0]),
      .req_coeff_channel    (req_tdata[39:32]),
      .req_coeff_multiplier (req_tdata[71:40]),
      .req_coeff_addend     (req_tdata[103:72]),
      .work_valid           (work_valid),
      .work_ready           (work_ready),
      .work_data            (work_data)
   );

   // Queue between front and back.
   pcrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (work_valid),
      .in_ready  (work_ready),
      .in_data   (work_data),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   // Back: arithmetic and result register.
   pcrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (back_valid),
      .work_ready (back_ready),
      .work_data  (back_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
